FILE: rtl/pal_pkg.sv
// Shared types and codes for the positional array list.
package pal_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned LEN_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT_AT    = 4'd0,
        ACT_INSERT_FIRST = 4'd1,
        ACT_INSERT_LAST  = 4'd2,
        ACT_DELETE_AT    = 4'd3,
        ACT_REPLACE      = 4'd4,
        ACT_READ         = 4'd5,
        ACT_SEARCH       = 4'd6,
        ACT_DELETE_KEY   = 4'd7,
        ACT_CLEAR        = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_NOKEY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_REMOVE_KEY,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

FILE: rtl/pal_req_if.sv
// Request channel: action, position and value with valid/ready.
interface pal_req_if;
    import pal_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink (input valid, input action, input position, input value,
                  output ready);
endinterface

FILE: rtl/pal_rsp_if.sv
// Response channel: value, found flag, status and length with valid/ready.
interface pal_rsp_if;
    import pal_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  result_value;
    logic                      found;
    logic [1:0]                status;
    logic [LEN_W-1:0]          length;

    modport source (output valid, output result_value, output found,
                    output status, output length, input ready);
    modport sink (input valid, input result_value, input found,
                  input status, input length, output ready);
endinterface

FILE: rtl/pal_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares against the key.
module pal_cell
    import pal_pkg::*;
#(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 5
)(
    input  logic                      clk,
    input  cell_ctl_t                 ctl,
    input  logic [CW-1:0]             pos,
    input  logic [CW-1:0]             count,
    input  logic signed [DATA_W-1:0]  left_entry,
    input  logic signed [DATA_W-1:0]  right_entry,
    input  logic                      hit_in,
    output logic signed [DATA_W-1:0]  entry,
    output logic                      hit_out,
    output logic signed [DATA_W-1:0]  rd_data
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     at_pos;
    logic                     after_pos;
    logic                     match;

    assign at_pos    = (IDX == pos);
    assign after_pos = (IDX > pos);
    assign match     = (IDX < count) && (entry_reg == ctl.value);
    assign hit_out   = hit_in || match;
    assign entry     = entry_reg;
    assign rd_data   = at_pos ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (at_pos)
                    entry_next = ctl.value;
                else if (after_pos)
                    entry_next = left_entry;
            end
            CELL_REMOVE:
            begin
                if (at_pos || after_pos)
                    entry_next = right_entry;
            end
            // close the gap from the first matching slot upward
            CELL_REMOVE_KEY:
            begin
                if (hit_out)
                    entry_next = right_entry;
            end
            CELL_WRITE:
            begin
                if (at_pos)
                    entry_next = ctl.value;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/positional_array_list.sv
// Top level of the positional array list: request decode, cell row and response register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit entries in a
// row of cells, one entry per cell, plus the current length.
// Requests arrive on req (valid/ready); each one causes exactly one response
// on rsp (valid/ready) with the entry read or deleted, a found flag, a status
// code and the length after the request.
// Every cell shifts, loads or compares in parallel, so a request is completed
// in the cycle it is accepted and its response appears on rsp in the cycle after.
// Throughput is one request per cycle while the receiver keeps rsp.ready high;
// the limit is the combinational key compare chain running through the cell row.
// The response register decouples the sides: a new request is taken while
// the previous response is being taken in the same cycle. If the receiver
// stalls, the response holds and req.ready stays low until it is taken.
// Reset empties the list and drops any pending response; entry contents are
// not cleared and are only read once rewritten.
module positional_array_list
    import pal_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
)(
    input  logic   clk,
    input  logic   rst_n,
    pal_req_if.sink   req,
    pal_rsp_if.source rsp
);

    localparam int unsigned CW_MIN = $clog2(CAPACITY + 1);
    localparam int unsigned CW     = (CW_MIN > LEN_W) ? CW_MIN : LEN_W;
    localparam logic [CW-1:0] CAP  = CW'(CAPACITY);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] rsp_value_reg;
    logic                     rsp_found_reg;
    status_t                  rsp_status_reg;
    logic [LEN_W-1:0]         rsp_length_reg;

    logic                     fire;
    logic                     full;
    logic                     pos_in_list;
    logic [CW-1:0]            req_pos;
    cell_ctl_t                ctl;
    logic [CW-1:0]            cell_pos;
    logic signed [DATA_W-1:0] rv;
    logic                     found;
    status_t                  status;
    logic signed [DATA_W-1:0] rd_any;

    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic signed [DATA_W-1:0] rd_w    [CAPACITY];
    logic                     hit_w   [CAPACITY+1];

    assign req.ready   = !rsp_valid_reg || rsp.ready;
    assign fire        = req.valid && req.ready;
    assign full        = (count_reg == CAP);
    assign req_pos     = CW'(req.position);
    assign pos_in_list = (req_pos < count_reg);
    assign hit_w[0]    = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = ctl.value;
        end
        else
        begin : g_mid
            assign left_w = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = entry_w[i];
        end
        else
        begin : g_inner
            assign right_w = entry_w[i+1];
        end

        pal_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .pos         (cell_pos),
            .count       (count_reg),
            .left_entry  (left_w),
            .right_entry (right_w),
            .hit_in      (hit_w[i]),
            .entry       (entry_w[i]),
            .hit_out     (hit_w[i+1]),
            .rd_data     (rd_w[i])
        );
    end

    // gather the entry at the requested position
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_any = rd_any | rd_w[i];
    end

    always_comb
    begin
        ctl.op     = CELL_HOLD;
        ctl.value  = req.value;
        cell_pos   = req_pos;
        count_next = count_reg;
        rv         = '0;
        found      = 1'b0;
        status     = ST_OK;
        case (action_t'(req.action))
            ACT_INSERT_AT, ACT_INSERT_FIRST, ACT_INSERT_LAST:
            begin
                if (action_t'(req.action) == ACT_INSERT_FIRST)
                    cell_pos = '0;
                else if (action_t'(req.action) == ACT_INSERT_LAST)
                    cell_pos = count_reg;
                if (full)
                    status = ST_FULL;
                else if (cell_pos > count_reg)
                    status = ST_BADPOS;
                else
                begin
                    ctl.op     = CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_DELETE_AT:
            begin
                if (pos_in_list)
                begin
                    ctl.op     = CELL_REMOVE;
                    rv         = rd_any;
                    count_next = count_reg - CW'(1);
                end
                else
                    status = ST_BADPOS;
            end
            ACT_REPLACE:
            begin
                if (pos_in_list)
                    ctl.op = CELL_WRITE;
                else
                    status = ST_BADPOS;
            end
            ACT_READ:
            begin
                if (pos_in_list)
                    rv = rd_any;
                else
                    status = ST_BADPOS;
            end
            ACT_SEARCH:
            begin
                found = hit_w[CAPACITY];
                if (!found)
                    status = ST_NOKEY;
            end
            ACT_DELETE_KEY:
            begin
                found = hit_w[CAPACITY];
                if (found)
                begin
                    ctl.op     = CELL_REMOVE_KEY;
                    rv         = req.value;
                    count_next = count_reg - CW'(1);
                end
                else
                    status = ST_NOKEY;
            end
            ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        // hold every cell unless a request transfers this cycle
        if (!fire)
        begin
            ctl.op     = CELL_HOLD;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_value_reg  <= rv;
            rsp_found_reg  <= found;
            rsp_status_reg <= status;
            rsp_length_reg <= count_next[LEN_W-1:0];
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.found        = rsp_found_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.length       = rsp_length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP)
        else $error("list length above capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (action_t'(req.action) == ACT_CLEAR) |=> rsp.valid && (count_reg == '0))
        else $error("clear did not empty the list");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (status == ST_FULL) |=> $stable(count_reg) && (count_reg == CAP))
        else $error("full status without a full list");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        fire && found |=> rsp.found && (rsp.status == ST_OK))
        else $error("match reported with an error status");

endmodule

FILE: test/tb.sv
// Testbench for the positional array list: directed and random requests checked against a list predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pal_pkg::*;

    localparam int LIST_CAP      = 16;
    localparam int IDLE_PCT      = 38;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_ITEMS  = 850;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     found;
        status_t                  status;
        logic [LEN_W-1:0]         length;
    } list_result_t;

    logic clk;
    logic rst_n;

    pal_req_if req_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list #(.CAPACITY(LIST_CAP)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predicted list contents and length
    logic signed [DATA_W-1:0] list_store [LIST_CAP];
    int                       list_len;

    list_result_t pending_results [$];
    int           error_count;
    int           cycle_count;
    bit           calm;
    int           stall_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic list_result_t list_apply(input logic [ACTION_W-1:0] act,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [DATA_W-1:0] val);
        list_result_t res;
        int           at;
        int           hit;
        res.value  = '0;
        res.found  = 1'b0;
        res.status = ST_OK;
        at         = -1;
        hit        = -1;
        case (act)
            ACT_INSERT_AT, ACT_INSERT_FIRST, ACT_INSERT_LAST:
            begin
                if (list_len >= LIST_CAP)
                    res.status = ST_FULL;
                else if (act == ACT_INSERT_AT && int'(pos) > list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    at = (act == ACT_INSERT_AT) ? int'(pos) :
                         (act == ACT_INSERT_FIRST) ? 0 : list_len;
                    for (int i = list_len; i > at; i--)
                        list_store[i] = list_store[i-1];
                    list_store[at] = val;
                    list_len++;
                end
            end
            ACT_DELETE_AT, ACT_REPLACE, ACT_READ:
            begin
                if (int'(pos) >= list_len)
                    res.status = ST_BADPOS;
                else if (act == ACT_REPLACE)
                    list_store[pos] = val;
                else
                begin
                    res.value = list_store[pos];
                    if (act == ACT_DELETE_AT)
                        at = int'(pos);
                end
            end
            ACT_SEARCH, ACT_DELETE_KEY:
            begin
                for (int i = 0; i < list_len; i++)
                    if (hit < 0 && list_store[i] == val)
                        hit = i;
                if (hit < 0)
                    res.status = ST_NOKEY;
                else
                begin
                    res.found = 1'b1;
                    if (act == ACT_DELETE_KEY)
                    begin
                        res.value = list_store[hit];
                        at        = hit;
                    end
                end
            end
            ACT_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        // close the gap left by a removal
        if (at >= 0 && (act == ACT_DELETE_AT || act == ACT_DELETE_KEY))
        begin
            for (int i = at; i + 1 < list_len; i++)
                list_store[i] = list_store[i+1];
            list_len--;
        end
        res.length = LEN_W'(list_len);
        return res;
    endfunction

    task automatic send_request(input logic [ACTION_W-1:0] act, input int pos,
                                input logic signed [DATA_W-1:0] val);
        @(negedge clk);
        if (!calm)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req_ch.valid = 1'b0;
                @(negedge clk);
            end
        end
        req_ch.valid    = 1'b1;
        req_ch.action   = act;
        req_ch.position = POS_W'(pos);
        req_ch.value    = val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(list_apply(act, POS_W'(pos), val));
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // receiver: random stalls, a counted hold-off, and calm stretches
    always @(negedge clk)
    begin
        if (stall_cycles > 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_cycles--;
        end
        else if (calm)
            rsp_ch.ready = 1'b1;
        else
            rsp_ch.ready = ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual value %h status %0d length %0d",
                         $time, rsp_ch.result_value, rsp_ch.status, rsp_ch.length);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.result_value !== want.value)
                begin
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.value, rsp_ch.result_value);
                    error_count++;
                end
                if (rsp_ch.found !== want.found)
                begin
                    $display("%0t: found expected %b actual %b",
                             $time, want.found, rsp_ch.found);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.length !== want.length)
                begin
                    $display("%0t: length expected %0d actual %0d",
                             $time, want.length, rsp_ch.length);
                    error_count++;
                end
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            4, 5:    return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(ACT_READ, 0, 32'sd1);
        send_request(ACT_DELETE_AT, 0, 32'sd1);
        send_request(ACT_REPLACE, 0, 32'sd9);
        send_request(ACT_SEARCH, 0, 32'sd5);
        send_request(ACT_DELETE_KEY, 0, 32'sd5);
        send_request(ACT_INSERT_AT, 1, 32'sd5);
    endtask

    task automatic test_basic_edits();
        send_request(ACT_INSERT_AT, 0, 32'sh8000_0000);
        send_request(ACT_INSERT_FIRST, 0, 32'sh7fff_ffff);
        send_request(ACT_INSERT_LAST, 0, -1);
        send_request(ACT_INSERT_AT, 3, 32'sd0);
        send_request(ACT_INSERT_AT, 1, -1);
        send_request(ACT_SEARCH, 0, -1);
        // first of two equal entries goes
        send_request(ACT_DELETE_KEY, 0, -1);
        send_request(ACT_READ, 0, 32'sd0);
        send_request(ACT_REPLACE, 2, 32'sh5555_aaaa);
        send_request(ACT_DELETE_AT, 0, 32'sd0);
        send_request(ACT_READ, list_len, 32'sd0);
        send_request(ACT_CLEAR, 0, 32'sd0);
    endtask

    task automatic test_unused_codes();
        send_request(ACT_INSERT_FIRST, 0, 32'sd3);
        send_request(ACT_UNUSED_LO, 0, 32'sd3);
        send_request(ACT_UNUSED_HI, 31, -1);
    endtask

    task automatic test_full_list();
        while (list_len < LIST_CAP)
            send_request(ACT_INSERT_LAST, 0, $urandom);
        // full wins over a bad position
        send_request(ACT_INSERT_AT, 17, 32'sd1);
        send_request(ACT_INSERT_FIRST, 0, 32'sd1);
        send_request(ACT_INSERT_LAST, 0, 32'sd1);
        send_request(ACT_READ, LIST_CAP - 1, 32'sd0);
        send_request(ACT_REPLACE, LIST_CAP - 1, 32'sh7fff_ffff);
        send_request(ACT_DELETE_AT, LIST_CAP - 1, 32'sd0);
        send_request(ACT_INSERT_AT, LIST_CAP - 1, 32'sh8000_0000);
        send_request(ACT_DELETE_AT, 0, 32'sd0);
        send_request(ACT_INSERT_AT, LIST_CAP, 32'sd2);
        send_request(ACT_CLEAR, 0, 32'sd0);
    endtask

    task automatic test_backpressure();
        calm         = 1'b1;
        stall_cycles = 60;
        for (int i = 0; i < 8; i++)
            send_request(ACT_INSERT_LAST, 0, rand_word());
        calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 6; i++)
            send_request(ACT_INSERT_FIRST, 0, rand_word());
        wait_results_done();
        send_request(ACT_READ, 0, 32'sd0);
        send_request(ACT_SEARCH, 0, list_store[list_len-1]);
    endtask

    task automatic test_random_mix(input int n_items);
        int                       fill_bias;
        int                       pick;
        int                       pos;
        logic [ACTION_W-1:0]      act;
        logic signed [DATA_W-1:0] val;
        fill_bias = 50;
        for (int n = 0; n < n_items; n++)
        begin
            if (n % 120 == 0)
                fill_bias = $urandom_range(20, 75);
            calm = (n >= 300 && n < 420);
            pick = $urandom_range(99);
            if (pick < fill_bias)
            begin
                case ($urandom_range(2))
                    0:       act = ACT_INSERT_AT;
                    1:       act = ACT_INSERT_FIRST;
                    default: act = ACT_INSERT_LAST;
                endcase
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 22)      act = ACT_DELETE_AT;
                else if (pick < 40) act = ACT_REPLACE;
                else if (pick < 58) act = ACT_READ;
                else if (pick < 74) act = ACT_SEARCH;
                else if (pick < 92) act = ACT_DELETE_KEY;
                else if (pick < 94) act = ACT_CLEAR;
                else                act = ACT_INSERT_AT;
                if (pick >= 97)
                    act = ACT_UNUSED_LO + ACTION_W'($urandom_range(6));
            end
            // position: mostly legal, sometimes just past the end or far out
            pick = $urandom_range(99);
            if (pick < 80)
                pos = (act == ACT_INSERT_AT || list_len == 0) ?
                      $urandom_range(list_len) : $urandom_range(list_len - 1);
            else if (pick < 95)
                pos = $urandom_range(LIST_CAP);
            else
                pos = $urandom_range(31);
            if ((act == ACT_SEARCH || act == ACT_DELETE_KEY) && list_len > 0
                && $urandom_range(99) < 70)
                val = list_store[$urandom_range(list_len - 1)];
            else
                val = rand_word();
            send_request(act, pos, val);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_CLEAR;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        list_len        = 0;
        error_count     = 0;
        cycle_count     = 0;
        calm            = 1'b0;
        stall_cycles    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_basic_edits();
        test_unused_codes();
        test_full_list();
        test_backpressure();
        test_drain_pause();
        test_random_mix(RANDOM_ITEMS);

        wait_results_done();
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
